[sv/i2cms_pkg.sv]
`timescale 1ns / 1ps

package i2cms_pkg;

  // Input word kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Transfer modes; MODE_RESTART marks the read phase of a register read.
  localparam logic [2:0] MODE_SWR     = 3'd0;
  localparam logic [2:0] MODE_SRD     = 3'd1;
  localparam logic [2:0] MODE_RWR     = 3'd2;
  localparam logic [2:0] MODE_RRD     = 3'd3;
  localparam logic [2:0] MODE_RESTART = 3'd4;

  // Transfer status codes.
  localparam logic [1:0] ST_ACTIVE = 2'd0;
  localparam logic [1:0] ST_PASSED = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;
  localparam logic [1:0] ST_NAK    = 2'd3;

  // Start request replies.
  localparam logic [1:0] REPLY_OK   = 2'd0;
  localparam logic [1:0] REPLY_BUSY = 2'd1;
  localparam logic [1:0] REPLY_BAD  = 2'd2;

  // Status register bits.
  localparam logic [11:0] FLG_SB      = 12'h001;
  localparam logic [11:0] FLG_ADDR    = 12'h002;
  localparam logic [11:0] FLG_RXNE    = 12'h040;
  localparam logic [11:0] FLG_TXE     = 12'h080;
  localparam logic [11:0] FLG_TXE_BTF = 12'h084;
  localparam logic [11:0] FLG_BERR    = 12'h100;
  localparam logic [11:0] FLG_ARLO    = 12'h200;
  localparam logic [11:0] FLG_AF      = 12'h400;
  localparam logic [11:0] FLG_OVR     = 12'h800;

  // Bus control actions.
  localparam logic [3:0] BUS_START = 4'h1;
  localparam logic [3:0] BUS_STOP  = 4'h2;
  localparam logic [3:0] BUS_ACK   = 4'h4;
  localparam logic [3:0] BUS_NOACK = 4'h8;

  // Interrupt control actions.
  localparam logic [2:0] IRQ_ALL   = 3'h1;
  localparam logic [2:0] IRQ_NOBUF = 3'h2;
  localparam logic [2:0] IRQ_NOEVT = 3'h4;

  // Completion signal bits.
  localparam logic [2:0] SIG_PASSED = 3'h1;
  localparam logic [2:0] SIG_FAILED = 3'h2;
  localparam logic [2:0] SIG_NAK    = 3'h4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  slave_addr;
    logic [7:0]  reg_addr;
    logic [15:0] byte_count;
    logic [2:0]  mode;
    logic [11:0] status_flags;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  request_reply;
    logic        data_reg_write;
    logic [7:0]  data_reg_value;
    logic        store_valid;
    logic [15:0] buffer_index;
    logic [7:0]  store_value;
    logic [3:0]  bus_actions;
    logic [2:0]  irq_actions;
    logic [11:0] flag_clear_mask;
    logic [1:0]  transfer_status;
    logic [2:0]  task_signal;
  } out_item_t;

endpackage

[sv/i2c_master_transfer_sequencer_unit.sv]
`timescale 1ns / 1ps

// I2C master transfer sequencer. Each input word is a start request, an event
// interrupt or an error interrupt, and each one yields exactly one result word
// that tells the driver what to write to the data register, which byte to
// store, which bus and interrupt controls to touch, which status flags to
// clear and how the transfer stands. A single level of logic on the
// transaction registers decides while the word is accepted; the result is
// registered on the same edge in the output register, or in the skid register
// while the output is stalled. A two-entry output buffer (output register plus
// skid register) lets the block take one more word while a result waits, so a
// new word can be taken every cycle until in_stall rises with both entries full.
module i2c_master_transfer_sequencer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cms_pkg::in_item_t in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cms_pkg::out_item_t out_item
);

  // Transaction registers.
  logic [7:0]  addr_byte;
  logic [7:0]  register_byte;
  logic [2:0]  current_mode;
  logic [1:0]  status_code;
  logic [15:0] bytes_left;
  logic [15:0] byte_position;

  logic [7:0]  addr_byte_next;
  logic [7:0]  register_byte_next;
  logic [2:0]  current_mode_next;
  logic [1:0]  status_code_next;
  logic [15:0] bytes_left_next;
  logic [15:0] byte_position_next;

  // Output buffer: the main register drives the port, the skid register
  // catches one word while the main one is stalled.
  logic                 skid_valid;
  i2cms_pkg::out_item_t skid_item;
  i2cms_pkg::out_item_t result;

  logic in_accept;
  logic out_take;
  logic wr_mode;
  logic read_phase;
  logic send_byte;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  assign wr_mode    = (current_mode == i2cms_pkg::MODE_RWR) ||
                      (current_mode == i2cms_pkg::MODE_SWR);
  assign read_phase = (current_mode == i2cms_pkg::MODE_RESTART) ||
                      (current_mode == i2cms_pkg::MODE_SRD);

  // Whether this event puts the next caller byte on the bus.
  always_comb begin
    send_byte = 1'b0;
    if (in_item.kind == i2cms_pkg::KIND_EVENT) begin
      if ((in_item.status_flags & i2cms_pkg::FLG_SB) != 12'd0) begin
        send_byte = 1'b0;
      end else if ((in_item.status_flags & i2cms_pkg::FLG_ADDR) != 12'd0) begin
        send_byte = (current_mode == i2cms_pkg::MODE_SWR) && (bytes_left != 16'd0);
      end else if ((in_item.status_flags & i2cms_pkg::FLG_TXE_BTF) ==
                   i2cms_pkg::FLG_TXE) begin
        send_byte = wr_mode && (bytes_left != 16'd0);
      end
    end
  end

  // Decision logic for one word.
  always_comb begin
    addr_byte_next     = addr_byte;
    register_byte_next = register_byte;
    current_mode_next  = current_mode;
    status_code_next   = status_code;
    bytes_left_next    = bytes_left;
    byte_position_next = byte_position;
    result             = '0;

    unique case (in_item.kind)
      i2cms_pkg::KIND_START: begin
        if (status_code == i2cms_pkg::ST_ACTIVE) begin
          result.request_reply = i2cms_pkg::REPLY_BUSY;
        end else if (in_item.mode > i2cms_pkg::MODE_RRD) begin
          result.request_reply = i2cms_pkg::REPLY_BAD;
        end else begin
          addr_byte_next          = {in_item.slave_addr, 1'b0};
          register_byte_next      = in_item.reg_addr;
          bytes_left_next         = in_item.byte_count;
          current_mode_next       = in_item.mode;
          byte_position_next      = 16'd0;
          status_code_next        = i2cms_pkg::ST_ACTIVE;
          result.irq_actions      = i2cms_pkg::IRQ_ALL;
          result.flag_clear_mask  = i2cms_pkg::FLG_OVR | i2cms_pkg::FLG_AF |
                                    i2cms_pkg::FLG_ARLO | i2cms_pkg::FLG_BERR;
          result.bus_actions      = i2cms_pkg::BUS_ACK | i2cms_pkg::BUS_START;
        end
      end
      i2cms_pkg::KIND_EVENT: begin
        if ((in_item.status_flags & i2cms_pkg::FLG_SB) != 12'd0) begin
          // Start condition sent: address byte, with the read bit in read phases.
          result.data_reg_write = 1'b1;
          result.data_reg_value = read_phase ? (addr_byte | 8'h01) : addr_byte;
        end else if ((in_item.status_flags & i2cms_pkg::FLG_ADDR) != 12'd0) begin
          if ((current_mode == i2cms_pkg::MODE_RWR) ||
              (current_mode == i2cms_pkg::MODE_RRD)) begin
            result.data_reg_write = 1'b1;
            result.data_reg_value = register_byte;
            if (current_mode == i2cms_pkg::MODE_RRD) begin
              current_mode_next  = i2cms_pkg::MODE_RESTART;
              result.bus_actions = result.bus_actions | i2cms_pkg::BUS_START;
            end
          end
          // A single byte read must drop ACK and queue STOP right away.
          if (read_phase && (bytes_left == 16'd1)) begin
            result.bus_actions = result.bus_actions | i2cms_pkg::BUS_NOACK |
                                 i2cms_pkg::BUS_STOP;
          end
        end else if ((in_item.status_flags & i2cms_pkg::FLG_TXE_BTF) ==
                     i2cms_pkg::FLG_TXE_BTF) begin
          if (wr_mode) begin
            result.bus_actions = i2cms_pkg::BUS_STOP;
            result.irq_actions = i2cms_pkg::IRQ_NOEVT;
            result.task_signal = i2cms_pkg::SIG_PASSED;
            status_code_next   = i2cms_pkg::ST_PASSED;
          end
        end else if (((in_item.status_flags & i2cms_pkg::FLG_TXE_BTF) !=
                      i2cms_pkg::FLG_TXE) &&
                     ((in_item.status_flags & i2cms_pkg::FLG_RXNE) != 12'd0)) begin
          if (bytes_left == 16'd0) begin
            result.irq_actions = i2cms_pkg::IRQ_NOBUF;
            result.task_signal = i2cms_pkg::SIG_PASSED;
            status_code_next   = i2cms_pkg::ST_PASSED;
          end else begin
            result.store_valid  = 1'b1;
            result.store_value  = in_item.rx_byte;
            result.buffer_index = byte_position;
            byte_position_next  = byte_position + 16'd1;
            bytes_left_next     = bytes_left - 16'd1;
            if (bytes_left == 16'd2) begin
              result.bus_actions = i2cms_pkg::BUS_NOACK | i2cms_pkg::BUS_STOP;
            end
            if (bytes_left == 16'd1) begin
              result.irq_actions = i2cms_pkg::IRQ_NOBUF;
              result.task_signal = i2cms_pkg::SIG_PASSED;
              status_code_next   = i2cms_pkg::ST_PASSED;
            end
          end
        end
        if (send_byte) begin
          result.data_reg_write = 1'b1;
          result.data_reg_value = in_item.tx_byte;
          result.buffer_index   = byte_position;
          byte_position_next    = byte_position + 16'd1;
          bytes_left_next       = bytes_left - 16'd1;
          if (bytes_left == 16'd1) begin
            result.irq_actions = result.irq_actions | i2cms_pkg::IRQ_NOBUF;
          end
        end
      end
      i2cms_pkg::KIND_ERROR: begin
        if ((in_item.status_flags & i2cms_pkg::FLG_AF) != 12'd0) begin
          // No acknowledge: only AF is cleared, and the bus is released.
          result.flag_clear_mask = i2cms_pkg::FLG_AF;
          result.bus_actions     = i2cms_pkg::BUS_STOP;
          result.irq_actions     = i2cms_pkg::IRQ_NOBUF;
          result.task_signal     = i2cms_pkg::SIG_FAILED | i2cms_pkg::SIG_NAK;
          status_code_next       = i2cms_pkg::ST_NAK;
        end else begin
          result.flag_clear_mask = in_item.status_flags &
                                   (i2cms_pkg::FLG_ARLO | i2cms_pkg::FLG_BERR |
                                    i2cms_pkg::FLG_OVR);
          result.task_signal     = i2cms_pkg::SIG_FAILED;
          status_code_next       = i2cms_pkg::ST_FAILED;
        end
      end
      default: begin
        // The unused kind leaves everything alone.
      end
    endcase

    result.transfer_status = status_code_next;
  end

  // Transaction state advances on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_byte     <= 8'd0;
      register_byte <= 8'd0;
      current_mode  <= i2cms_pkg::MODE_SWR;
      status_code   <= i2cms_pkg::ST_PASSED;
      bytes_left    <= 16'd0;
      byte_position <= 16'd0;
    end else if (in_accept) begin
      addr_byte     <= addr_byte_next;
      register_byte <= register_byte_next;
      current_mode  <= current_mode_next;
      status_code   <= status_code_next;
      bytes_left    <= bytes_left_next;
      byte_position <= byte_position_next;
    end
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (in_accept) begin
        out_item <= result;
      end
    end else if (in_accept) begin
      skid_item <= result;
    end
  end

  // The skid register only fills behind a stalled output register.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid register holds a word while the output is empty");

  // An accepted start request marks the transfer active.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_item.kind == i2cms_pkg::KIND_START) &&
     (status_code != i2cms_pkg::ST_ACTIVE) &&
     (in_item.mode <= i2cms_pkg::MODE_RRD))
    |=> (status_code == i2cms_pkg::ST_ACTIVE))
    else $error("start request did not begin a transfer");

  // A byte is never written to the data register and stored in the same word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.data_reg_write && out_item.store_valid))
    else $error("result both writes and stores a byte");

  // No received byte means an empty store value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.store_valid) |-> (out_item.store_value == 8'd0))
    else $error("store value set without a stored byte");

endmodule
